// ===== design/pirpt_pkg.sv =====
`timescale 1ns / 1ps

package pirpt_pkg;

	localparam int MaxSides = 64;
	localparam int TrigFracBits = 14;
	localparam int FullTurn = 360;
	localparam int HalfTurn = 180;
	localparam int QuarterTurn = 90;
	localparam longint unsigned PiQ30 = 64'd3373259426;

	localparam int CoordW = 16;
	localparam int RadW = 15;
	localparam int SideCfgW = 7;
	localparam int AddrW = 4;
	localparam int DataW = 32;

	localparam int SideW = $clog2(MaxSides + 1);
	localparam int StepW = $clog2(HalfTurn);
	localparam int AngW = $clog2(FullTurn + QuarterTurn + 1);
	localparam int IdxW = $clog2(QuarterTurn + 1);
	localparam int MagW = TrigFracBits + 1;
	localparam int VertW = CoordW + 2;
	localparam int DiffW = VertW + 1;
	localparam int MulW = (MagW + 1 > DiffW) ? MagW + 1 : DiffW;
	localparam int ProdW = 2 * MulW;

	typedef enum logic [1:0] {
		RegCenterX,
		RegCenterY,
		RegRadius,
		RegSideCount
	} reg_idx_t;

	typedef struct packed {
		logic [IdxW-1:0] idx;
		logic            neg;
	} fold_t;

	typedef logic [QuarterTurn:0][MagW-1:0] sin_tab_t;

	function automatic logic [MagW-1:0] sin_quadrant(input int unsigned d);
		logic [63:0] x;
		logic [63:0] term;
		logic signed [63:0] sum;
		logic [63:0] r;
		x = (64'(d) * PiQ30 + 64'(HalfTurn / 2)) / HalfTurn;
		term = x;
		sum = signed'(x);
		term = (term * x) >> 30; term = (term * x) >> 30; term = term / 6;   sum = sum - signed'(term);
		term = (term * x) >> 30; term = (term * x) >> 30; term = term / 20;  sum = sum + signed'(term);
		term = (term * x) >> 30; term = (term * x) >> 30; term = term / 42;  sum = sum - signed'(term);
		term = (term * x) >> 30; term = (term * x) >> 30; term = term / 72;  sum = sum + signed'(term);
		term = (term * x) >> 30; term = (term * x) >> 30; term = term / 110; sum = sum - signed'(term);
		term = (term * x) >> 30; term = (term * x) >> 30; term = term / 156; sum = sum + signed'(term);
		term = (term * x) >> 30; term = (term * x) >> 30; term = term / 210; sum = sum - signed'(term);
		term = (term * x) >> 30; term = (term * x) >> 30; term = term / 272; sum = sum + signed'(term);
		term = (term * x) >> 30; term = (term * x) >> 30; term = term / 342; sum = sum - signed'(term);
		term = (term * x) >> 30; term = (term * x) >> 30; term = term / 420; sum = sum + signed'(term);
		term = (term * x) >> 30; term = (term * x) >> 30; term = term / 506; sum = sum - signed'(term);
		if (sum < 0) begin
			sum = 0;
		end
		r = (unsigned'(sum) + (64'd1 << (29 - TrigFracBits))) >> (30 - TrigFracBits);
		return r[MagW-1:0];
	endfunction

	function automatic sin_tab_t build_sin_tab();
		sin_tab_t t;
		for (int d = 0; d <= QuarterTurn; d++) begin
			t[d] = sin_quadrant(d);
		end
		return t;
	endfunction

	localparam sin_tab_t SinTab = build_sin_tab();

	function automatic logic [StepW-1:0] step_of(input int unsigned n);
		logic [StepW-1:0] s;
		case (n) inside
			3:          s = StepW'(120);
			4:          s = StepW'(90);
			5:          s = StepW'(72);
			6:          s = StepW'(60);
			7:          s = StepW'(51);
			8:          s = StepW'(45);
			9:          s = StepW'(40);
			10:         s = StepW'(36);
			11:         s = StepW'(32);
			12:         s = StepW'(30);
			13:         s = StepW'(27);
			14:         s = StepW'(25);
			15:         s = StepW'(24);
			16:         s = StepW'(22);
			17:         s = StepW'(21);
			18:         s = StepW'(20);
			[19:20]:    s = StepW'(18);
			21:         s = StepW'(17);
			22:         s = StepW'(16);
			[23:24]:    s = StepW'(15);
			25:         s = StepW'(14);
			[26:27]:    s = StepW'(13);
			[28:30]:    s = StepW'(12);
			[31:32]:    s = StepW'(11);
			[33:36]:    s = StepW'(10);
			[37:40]:    s = StepW'(9);
			[41:45]:    s = StepW'(8);
			[46:51]:    s = StepW'(7);
			[52:60]:    s = StepW'(6);
			[61:72]:    s = StepW'(5);
			[73:90]:    s = StepW'(4);
			[91:120]:   s = StepW'(3);
			[121:180]:  s = StepW'(2);
			default:    s = StepW'(1);
		endcase
		return s;
	endfunction

endpackage

// ===== design/point_in_regular_polygon_test.sv =====
// Tests whether a query point lies inside a regular polygon set by the centre, radius and
// side count registers, using the ray-crossing rule against the polygon's edges. Each beat
// on the input channel gives exactly one result beat. With n sides (side_count limited to
// 64) one shared signed multiplier computes every vertex offset and both cross products of
// each edge in turn, so the edges are handled one after another; a side count below three
// gives a result of zero. A result that waits for the output register holds the block until
// it is taken. The input is ready again as soon as the result is placed in the output
// register.
`timescale 1ns / 1ps

module point_in_regular_polygon_test (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [pirpt_pkg::AddrW-1:0]         paddr,
	input  logic [pirpt_pkg::DataW-1:0]         pwdata,
	output logic [pirpt_pkg::DataW-1:0]         prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [pirpt_pkg::CoordW-1:0] point_x,
	input  logic signed [pirpt_pkg::CoordW-1:0] point_y,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                inside_res
);
	import pirpt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_VX,
		S_VY,
		S_VE,
		S_LHS,
		S_RHS,
		S_CMP,
		S_DONE
	} state_t;

	logic signed [CoordW-1:0] center_x_q;
	logic signed [CoordW-1:0] center_y_q;
	logic [RadW-1:0]          radius_q;
	logic [SideCfgW-1:0]      side_count_q;

	state_t                   state_q;
	logic signed [CoordW-1:0] px_q;
	logic signed [CoordW-1:0] py_q;
	logic [SideW-1:0]         n_q;
	logic [SideW-1:0]         k_q;
	logic [StepW-1:0]         step_q;
	logic [AngW-1:0]          angle_q;
	logic                     first_q;
	logic                     parity_q;
	logic signed [VertW-1:0]  x0_q;
	logic signed [VertW-1:0]  y0_q;
	logic signed [VertW-1:0]  x1_q;
	logic signed [VertW-1:0]  y1_q;
	logic signed [VertW-1:0]  vx_q;
	logic signed [VertW-1:0]  vy_q;
	logic signed [ProdW-1:0]  prod_q;
	logic signed [ProdW-1:0]  lhs_q;
	logic                     out_valid_q;
	logic                     inside_q;

	logic                     cfg_wr;
	logic [SideW-1:0]         n_c;
	logic [AngW-1:0]          cos_ang;
	fold_t                    cos_f;
	fold_t                    sin_f;
	logic [MagW-1:0]          cos_mag;
	logic [MagW-1:0]          sin_mag;
	logic signed [MulW-1:0]   mul_a;
	logic signed [MulW-1:0]   mul_b;
	logic signed [ProdW-1:0]  prod_c;
	logic [RadW+MagW:0]       rnd_sum;
	logic [RadW-1:0]          off_mag;
	logic signed [VertW-1:0]  off_s;
	logic signed [VertW-1:0]  vert_c;
	logic                     off_neg;
	logic signed [DiffW-1:0]  dpx;
	logic signed [DiffW-1:0]  dpy;
	logic signed [DiffW-1:0]  dvx;
	logic signed [DiffW-1:0]  dvy;
	logic signed [VertW-1:0]  py_ext;
	logic                     crosses;
	logic                     hit;
	logic                     last_edge;

	function automatic fold_t fold(input logic [AngW-1:0] a);
		fold_t f;
		if (a <= AngW'(QuarterTurn)) begin
			f.idx = IdxW'(a);
			f.neg = 1'b0;
		end else if (a <= AngW'(HalfTurn)) begin
			f.idx = IdxW'(AngW'(HalfTurn) - a);
			f.neg = 1'b0;
		end else if (a <= AngW'(HalfTurn + QuarterTurn)) begin
			f.idx = IdxW'(a - AngW'(HalfTurn));
			f.neg = 1'b1;
		end else begin
			f.idx = IdxW'(AngW'(FullTurn) - a);
			f.neg = 1'b1;
		end
		return f;
	endfunction

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			radius_q <= '0;
			side_count_q <= SideCfgW'(3);
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[3:2]))
				RegCenterX:   center_x_q <= pwdata[CoordW-1:0];
				RegCenterY:   center_y_q <= pwdata[CoordW-1:0];
				RegRadius:    radius_q <= pwdata[RadW-1:0];
				RegSideCount: side_count_q <= pwdata[SideCfgW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			RegCenterX:   prdata = DataW'(unsigned'(center_x_q));
			RegCenterY:   prdata = DataW'(unsigned'(center_y_q));
			RegRadius:    prdata = DataW'(radius_q);
			RegSideCount: prdata = DataW'(side_count_q);
			default:      prdata = '0;
		endcase
	end

	always_comb begin
		n_c = (int'(side_count_q) > MaxSides) ? SideW'(MaxSides) : SideW'(side_count_q);
		cos_ang = angle_q + AngW'(QuarterTurn);
		if (cos_ang >= AngW'(FullTurn)) begin
			cos_ang = cos_ang - AngW'(FullTurn);
		end
		cos_f = fold(cos_ang);
		sin_f = fold(angle_q);
		cos_mag = SinTab[cos_f.idx];
		sin_mag = SinTab[sin_f.idx];
	end

	always_comb begin
		dpx = DiffW'(px_q) - DiffW'(x1_q);
		dpy = DiffW'(py_q) - DiffW'(y1_q);
		dvx = DiffW'(vx_q) - DiffW'(x1_q);
		dvy = DiffW'(vy_q) - DiffW'(y1_q);
		case (state_q)
			S_VX: begin
				mul_a = signed'(MulW'(radius_q));
				mul_b = signed'(MulW'(cos_mag));
			end
			S_VY: begin
				mul_a = signed'(MulW'(radius_q));
				mul_b = signed'(MulW'(sin_mag));
			end
			S_LHS: begin
				mul_a = MulW'(dpx);
				mul_b = MulW'(dvy);
			end
			S_RHS: begin
				mul_a = MulW'(dpy);
				mul_b = MulW'(dvx);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod_c = ProdW'(mul_a) * ProdW'(mul_b);
	end

	always_comb begin
		off_neg = (state_q == S_VY) ? cos_f.neg : sin_f.neg;
		rnd_sum = {1'b0, prod_q[RadW+MagW-1:0]}
			+ ((RadW+MagW+1)'(1) << (TrigFracBits - 1));
		off_mag = rnd_sum[TrigFracBits +: RadW];
		off_s = off_neg ? -signed'(VertW'(off_mag)) : signed'(VertW'(off_mag));
		vert_c = ((state_q == S_VY) ? VertW'(center_x_q) : VertW'(center_y_q)) + off_s;
		py_ext = VertW'(py_q);
		crosses = (py_ext < y1_q) != (py_ext < vy_q);
		hit = (vy_q > y1_q) ? (lhs_q < prod_q) : (lhs_q > prod_q);
		last_edge = (k_q == n_q - SideW'(1));
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign inside_res = inside_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			first_q <= 1'b0;
			parity_q <= 1'b0;
			k_q <= '0;
			n_q <= '0;
			step_q <= '0;
			angle_q <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						px_q <= point_x;
						py_q <= point_y;
						n_q <= n_c;
						step_q <= step_of(int'(n_c));
						k_q <= '0;
						angle_q <= '0;
						first_q <= 1'b1;
						parity_q <= 1'b0;
						state_q <= (n_c < SideW'(3)) ? S_DONE : S_VX;
					end
				end
				S_VX: begin
					if (!first_q && last_edge) begin
						vx_q <= x0_q;
						vy_q <= y0_q;
						state_q <= S_LHS;
					end else begin
						prod_q <= prod_c;
						state_q <= S_VY;
					end
				end
				S_VY: begin
					vx_q <= vert_c;
					prod_q <= prod_c;
					state_q <= S_VE;
				end
				S_VE: begin
					if (first_q) begin
						x0_q <= vx_q;
						y0_q <= vert_c;
						x1_q <= vx_q;
						y1_q <= vert_c;
						first_q <= 1'b0;
						angle_q <= angle_q + AngW'(step_q);
						state_q <= S_VX;
					end else begin
						vy_q <= vert_c;
						state_q <= S_LHS;
					end
				end
				S_LHS: begin
					prod_q <= prod_c;
					state_q <= S_RHS;
				end
				S_RHS: begin
					lhs_q <= prod_q;
					prod_q <= prod_c;
					state_q <= S_CMP;
				end
				S_CMP: begin
					parity_q <= parity_q ^ (crosses && hit);
					x1_q <= vx_q;
					y1_q <= vy_q;
					if (last_edge) begin
						state_q <= S_DONE;
					end else begin
						k_q <= k_q + SideW'(1);
						angle_q <= angle_q + AngW'(step_q);
						state_q <= S_VX;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						inside_q <= parity_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
